// File: rtl/core/imu_complementary_tilt_filter_macros.svh
// Assertion macros of the tilt filter RTL.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ICT_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tilt filter check failed");
`define ICT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tilt filter check failed");
`else
`define ICT_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ICT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// File: rtl/core/ict_pkg.sv
// Constants, types and helper functions of the tilt filter.
package ict_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int TAB_LEN         = 32;
  localparam int STEPS           = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int SHIFT_W         = $clog2(TAB_LEN);
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int RND_SHIFT       = 32 - ANGLE_FRAC_BITS;
  localparam int PRESCALE_BITS   = 12;
  localparam int RAW_W           = 16;
  localparam int ANGLE_W         = 26;
  localparam int WEIGHT_W        = 16;
  localparam int STEP_W          = 24;
  localparam int X_W             = 32;
  localparam int Z_W             = 42;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STEP     = 8'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd64225;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 24'd327860;

  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;
  localparam logic [63:0] RAD2DEG_FRAC = 64'h4BB834C7;

  localparam logic signed [Z_W-1:0] DEG90 = Z_W'(64'd90 <<< 32);
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef logic signed [Z_W-1:0] atan_tab_t [STEPS];

  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } cell_data_t;

  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] rad;
    logic [63:0] rh;
    logic [63:0] rl;
    logic [63:0] deg;
    logic [63:0] t;
    int          sh;
    tab[0] = Z_W'(64'd45 <<< 32);
    for (int i = 1; i < STEPS; i++) begin
      rad = '0;
      for (int k = 0; k < 32; k++) begin
        sh = 56 - i * (2 * k + 1);
        if (sh >= 0) begin
          t = udiv64(64'd1 << sh, 64'(2 * k + 1));
          if ((k % 2) == 1) begin
            rad = rad - t;
          end else begin
            rad = rad + t;
          end
        end
      end
      rh  = rad >> 28;
      rl  = rad & 64'h0FFF_FFFF;
      deg = ((rad * 64'd57) >> 24) + ((rh * RAD2DEG_FRAC + ((rl * RAD2DEG_FRAC) >> 28)) >> 28);
      tab[i] = Z_W'(deg);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

  function automatic logic signed [ANGLE_W-1:0] to_frac(logic signed [Z_W-1:0] v);
    logic signed [Z_W-1:0] s;
    s = (v + Z_W'(64'd1 << (RND_SHIFT - 1))) >>> RND_SHIFT;
    return s[ANGLE_W-1:0];
  endfunction

endpackage

// File: rtl/core/ict_if.sv
// Channel interfaces of the tilt filter: samples, angles and configuration.
interface ict_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [ict_pkg::RAW_W-1:0]    accel_x;
  logic signed [ict_pkg::RAW_W-1:0]    accel_y;
  logic signed [ict_pkg::RAW_W-1:0]    accel_z;
  logic signed [ict_pkg::RAW_W-1:0]    gyro_x;
  logic signed [ict_pkg::RAW_W-1:0]    gyro_y;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface ict_angle_if;
  logic                                valid;
  logic                                ready;
  logic signed [ict_pkg::ANGLE_W-1:0]  roll_out;
  logic signed [ict_pkg::ANGLE_W-1:0]  pitch_out;
  modport source (output valid, roll_out, pitch_out, input ready);
  modport sink (input valid, roll_out, pitch_out, output ready);
endinterface

interface ict_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ict_pkg::CFG_IDX_W-1:0]       index;
  logic [ict_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ict_cordic_cell.sv
// One vectoring CORDIC cell: a single micro-rotation per cycle.
module ict_cordic_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ict_pkg::SHIFT_W-1:0]         shift,
  input  logic signed [ict_pkg::Z_W-1:0]      atan_step,
  input  ict_pkg::cell_data_t                 din,
  output ict_pkg::cell_data_t                 dout
);

  logic                               valid;
  logic                               zero;
  logic signed [ict_pkg::X_W-1:0]     x;
  logic signed [ict_pkg::X_W-1:0]     y;
  logic signed [ict_pkg::Z_W-1:0]     z;
  logic signed [ict_pkg::X_W-1:0]     dx;
  logic signed [ict_pkg::X_W-1:0]     dy;

  assign dx = din.y >>> shift;
  assign dy = din.x >>> shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    zero <= din.zero;
    if (!din.y[ict_pkg::X_W-1]) begin
      x <= din.x + dx;
      y <= din.y - dy;
      z <= din.z + atan_step;
    end else begin
      x <= din.x - dx;
      y <= din.y + dy;
      z <= din.z - atan_step;
    end
  end

  assign dout = '{valid: valid, zero: zero, x: x, y: y, z: z};

endmodule

// File: rtl/core/ict_mix.sv
// Complementary blend of one axis: gyro prediction, weighted mix, rounding, saturation.
module ict_mix (
  input  logic                                 clk,
  input  logic signed [ict_pkg::ANGLE_W-1:0]   angle,
  input  logic signed [ict_pkg::RAW_W-1:0]     gyro,
  input  logic signed [ict_pkg::ANGLE_W-1:0]   acc,
  input  logic [ict_pkg::WEIGHT_W-1:0]         weight,
  input  logic [ict_pkg::STEP_W-1:0]           step,
  output logic signed [ict_pkg::ANGLE_W-1:0]   angle_next
);

  localparam int PRED_W = ict_pkg::ANGLE_W + 1;
  localparam int PROD_W = PRED_W + ict_pkg::WEIGHT_W + 2;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RES_W  = SUM_W - ict_pkg::WEIGHT_W;

  logic signed [ict_pkg::Z_W-1:0]       gyro_prod;
  logic signed [ict_pkg::ANGLE_W-1:0]   gyro_term;
  logic signed [PRED_W-1:0]             pred;
  logic [ict_pkg::WEIGHT_W:0]           beta;
  logic signed [PROD_W-1:0]             prod_a;
  logic signed [PROD_W-1:0]             prod_b;
  logic signed [SUM_W-1:0]              sum;
  logic signed [RES_W-1:0]              res;

  assign gyro_prod = gyro * $signed({1'b0, step});
  assign pred      = PRED_W'(angle) + PRED_W'(gyro_term);
  assign beta      = (ict_pkg::WEIGHT_W+1)'(1 << ict_pkg::WEIGHT_W) - {1'b0, weight};

  always_ff @(posedge clk) begin
    gyro_term <= ict_pkg::to_frac(gyro_prod);
    prod_a    <= $signed({1'b0, weight}) * pred;
    prod_b    <= $signed({1'b0, beta}) * acc;
  end

  always_comb begin
    sum = SUM_W'(prod_a) + SUM_W'(prod_b) + SUM_W'(1 << (ict_pkg::WEIGHT_W - 1));
    res = RES_W'(sum >>> ict_pkg::WEIGHT_W);
    if (res > RES_W'(ict_pkg::ANGLE_MAX)) begin
      angle_next = ict_pkg::ANGLE_MAX;
    end else if (res < RES_W'(ict_pkg::ANGLE_MIN)) begin
      angle_next = ict_pkg::ANGLE_MIN;
    end else begin
      angle_next = res[ict_pkg::ANGLE_W-1:0];
    end
  end

endmodule

// File: rtl/core/imu_complementary_tilt_filter.sv
// Top level of the complementary roll and pitch tilt filter.
//
// Samples arrive on the samples channel: raw accelerometer x, y, z and gyro x, y.
// Each transfer yields one transfer on the angles channel with the filtered roll
// and pitch in degrees, 16 fractional bits, saturated to +-512 degrees.
// The cfg channel writes register 0 (gyro weight, 16 fractional bits) and
// register 1 (degrees per gyro step, 32 fractional bits); other indices are
// ignored. Writes are always accepted and are meant for an idle block.
// The accelerometer angles come from a row of CORDIC_STEPS cells that the
// roll vector and then the pitch vector pass through in turn, with a gain
// correction multiply in between, followed by a blend per axis. The next sample
// is taken once the previous one has left the cell row and blend. A finished
// result waits in the output register; the block still takes a new sample
// meanwhile but holds its blend until the register frees.
// Synchronous reset clears both stored angles and loads the default weights.
`include "imu_complementary_tilt_filter_macros.svh"

module imu_complementary_tilt_filter (
  input  logic        clk,
  input  logic        rst,
  ict_sample_if.sink  samples,
  ict_angle_if.source angles,
  ict_cfg_if.sink     cfg
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROLL, S_SCALE, S_PITCH, S_GYRO, S_MIX, S_SAT
  } state_t;

  state_t                              state;
  logic [ict_pkg::WEIGHT_W-1:0]        filter_weight;
  logic [ict_pkg::STEP_W-1:0]          gyro_step;
  logic signed [ict_pkg::ANGLE_W-1:0]  roll_angle;
  logic signed [ict_pkg::ANGLE_W-1:0]  pitch_angle;
  logic signed [ict_pkg::ANGLE_W-1:0]  roll_acc;
  logic signed [ict_pkg::ANGLE_W-1:0]  pitch_acc;
  logic signed [ict_pkg::RAW_W-1:0]    ax;
  logic signed [ict_pkg::RAW_W-1:0]    gx;
  logic signed [ict_pkg::RAW_W-1:0]    gy;
  logic [63:0]                         mag_prod;
  logic                                out_valid;
  logic signed [ict_pkg::ANGLE_W-1:0]  roll_q;
  logic signed [ict_pkg::ANGLE_W-1:0]  pitch_q;
  logic signed [ict_pkg::ANGLE_W-1:0]  roll_next;
  logic signed [ict_pkg::ANGLE_W-1:0]  pitch_next;
  logic signed [ict_pkg::ANGLE_W-1:0]  tail_angle;
  logic [31:0]                         tail_mag;
  logic                                in_xfer;
  logic                                out_free;
  ict_pkg::cell_data_t                 head;
  ict_pkg::cell_data_t                 tail;
  ict_pkg::cell_data_t                 cell_in  [ict_pkg::STEPS];
  ict_pkg::cell_data_t                 cell_out [ict_pkg::STEPS];
  logic [ict_pkg::STEPS-1:0]           cell_valid;

  function automatic ict_pkg::cell_data_t launch(logic signed [ict_pkg::X_W-1:0] x,
                                                 logic signed [ict_pkg::X_W-1:0] y,
                                                 logic v);
    ict_pkg::cell_data_t d;
    d.valid = v;
    d.zero  = (x == '0) && (y == '0);
    d.x     = x;
    d.y     = y;
    d.z     = '0;
    if (x[ict_pkg::X_W-1]) begin
      if (!y[ict_pkg::X_W-1]) begin
        d.x = y;
        d.y = -x;
        d.z = ict_pkg::DEG90;
      end else begin
        d.x = -y;
        d.y = x;
        d.z = -ict_pkg::DEG90;
      end
    end
    return d;
  endfunction

  assign samples.ready = (state == S_IDLE);
  assign in_xfer       = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;
  assign out_free      = !out_valid || angles.ready;

  always_comb begin
    if (state == S_SCALE) begin
      head = launch(ict_pkg::X_W'(mag_prod[63:32]),
                    -(ict_pkg::X_W'(ax) <<< ict_pkg::PRESCALE_BITS), 1'b1);
    end else begin
      head = launch(ict_pkg::X_W'(samples.accel_z) <<< ict_pkg::PRESCALE_BITS,
                    ict_pkg::X_W'(samples.accel_y) <<< ict_pkg::PRESCALE_BITS, in_xfer);
    end
  end

  for (genvar g = 0; g < ict_pkg::STEPS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_in[g] = head;
    end else begin : g_next
      assign cell_in[g] = cell_out[g-1];
    end
    ict_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (ict_pkg::SHIFT_W'(g)),
      .atan_step (ict_pkg::ATAN_TAB[g]),
      .din       (cell_in[g]),
      .dout      (cell_out[g])
    );
    assign cell_valid[g] = cell_out[g].valid;
  end

  assign tail       = cell_out[ict_pkg::STEPS-1];
  assign tail_angle = tail.zero ? '0 : ict_pkg::to_frac(tail.z);
  assign tail_mag   = tail.zero ? '0 : tail.x[31:0];

  ict_mix u_roll_mix (
    .clk        (clk),
    .angle      (roll_angle),
    .gyro       (gx),
    .acc        (roll_acc),
    .weight     (filter_weight),
    .step       (gyro_step),
    .angle_next (roll_next)
  );

  ict_mix u_pitch_mix (
    .clk        (clk),
    .angle      (pitch_angle),
    .gyro       (gy),
    .acc        (pitch_acc),
    .weight     (filter_weight),
    .step       (gyro_step),
    .angle_next (pitch_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      filter_weight <= ict_pkg::WEIGHT_RESET;
      gyro_step     <= ict_pkg::STEP_RESET;
      roll_angle    <= '0;
      pitch_angle   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          ict_pkg::CFG_FILTER_WEIGHT: filter_weight <= cfg.data[ict_pkg::WEIGHT_W-1:0];
          ict_pkg::CFG_GYRO_STEP:     gyro_step     <= cfg.data[ict_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (state == S_SAT && out_free) begin
        out_valid <= 1'b1;
      end else if (angles.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            ax    <= samples.accel_x;
            gx    <= samples.gyro_x;
            gy    <= samples.gyro_y;
            state <= S_ROLL;
          end
        end
        S_ROLL: begin
          if (tail.valid) begin
            roll_acc <= tail_angle;
            mag_prod <= 64'(tail_mag) * 64'(ict_pkg::INV_GAIN_Q32);
            state    <= S_SCALE;
          end
        end
        S_SCALE: state <= S_PITCH;
        S_PITCH: begin
          if (tail.valid) begin
            pitch_acc <= tail_angle;
            state     <= S_GYRO;
          end
        end
        S_GYRO: state <= S_MIX;
        S_MIX:  state <= S_SAT;
        S_SAT: begin
          if (out_free) begin
            roll_angle  <= roll_next;
            pitch_angle <= pitch_next;
            roll_q      <= roll_next;
            pitch_q     <= pitch_next;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign angles.valid     = out_valid;
  assign angles.roll_out  = roll_q;
  assign angles.pitch_out = pitch_q;

  `ICT_ASSERT_IMPLIES(a_single_vector, clk, rst, 1'b1, $countones(cell_valid) <= 1)
  `ICT_ASSERT_NEXT(a_launch_roll, clk, rst, in_xfer, cell_valid[0] && state == S_ROLL)
  `ICT_ASSERT_IMPLIES(a_tail_expected, clk, rst, tail.valid, state == S_ROLL || state == S_PITCH)

endmodule

// File: tb/ict_tb_if.sv
`timescale 1ns / 1ps
// Testbench copy note: the channel interfaces come from the RTL; this file holds shared tb types.
package ict_tb_pkg;
  typedef struct {
    logic signed [25:0] roll;
    logic signed [25:0] pitch;
  } tilt_t;
endpackage

// File: tb/tb_imu_complementary_tilt_filter.sv
`timescale 1ns / 1ps
// Testbench of the tilt filter: random and directed samples checked against a tilt predictor.
module tb_imu_complementary_tilt_filter;

  logic clk = 1'b0;
  logic rst = 1'b1;
  ict_sample_if samples ();
  ict_angle_if  angles ();
  ict_cfg_if    cfg ();

  imu_complementary_tilt_filter uut (
    .clk(clk), .rst(rst), .samples(samples), .angles(angles), .cfg(cfg)
  );

  always #1 clk = ~clk;

  longint               atan_deg [32];
  longint               weight_q;
  longint               step_q;
  longint               roll_q;
  longint               pitch_q;
  ict_tb_pkg::tilt_t    tilt_queue [$];
  int                   errors = 0;
  int                   cycles = 0;
  bit                   calm = 1'b0;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void fill_atan();
    longint unsigned rad, rh, rl, t;
    int sh;
    atan_deg[0] = 45 * 64'sd4294967296;
    for (int i = 1; i < 32; i++) begin
      rad = 0;
      for (int k = 0; k < 64; k++) begin
        sh = 56 - i * (2 * k + 1);
        if (sh >= 0) begin
          t = (64'd1 << sh) / (2 * k + 1);
          if (k % 2) rad = rad - t;
          else rad = rad + t;
        end
      end
      rh = rad >> 28;
      rl = rad & 64'h0FFF_FFFF;
      atan_deg[i] = ((rad * 57) >> 24)
                  + ((rh * 64'h4BB834C7 + ((rl * 64'h4BB834C7) >> 28)) >> 28);
    end
  endfunction

  task automatic vector_angle(input longint x0, input longint y0, output longint ang,
                              output longint mag);
    longint x, y, z, dx, dy, t;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
    end else begin
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = 90 * 64'sd4294967296;
        end else begin
          x = -y;
          y = t;
          z = -90 * 64'sd4294967296;
        end
      end
      for (int i = 0; i < ict_pkg::STEPS; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += atan_deg[i];
        end else begin
          x -= dx;
          y += dy;
          z -= atan_deg[i];
        end
      end
      ang = z;
      mag = x;
    end
  endtask

  function automatic longint round_q16(longint v);
    return floor_shift(v + 32768, 16);
  endfunction

  function automatic longint blend(longint angle, longint gyro, longint acc);
    longint pred, mix, r;
    pred = angle + round_q16(gyro * step_q);
    mix = weight_q * pred + (65536 - weight_q) * acc;
    r = floor_shift(mix + 32768, 16);
    if (r > 33554431) r = 33554431;
    if (r < -33554432) r = -33554432;
    return r;
  endfunction

  task automatic predict_tilt(input logic signed [15:0] ax, ay, az, gx, gy);
    longint ang, mag, roll_acc, pitch_acc;
    longint unsigned m;
    ict_tb_pkg::tilt_t e;
    vector_angle(longint'(az) * 4096, longint'(ay) * 4096, ang, mag);
    roll_acc = round_q16(ang);
    m = (longint'(mag) * 64'h9B74EDA8) >> 32;
    vector_angle(longint'(m), -longint'(ax) * 4096, ang, mag);
    pitch_acc = round_q16(ang);
    roll_q = blend(roll_q, gx, roll_acc);
    pitch_q = blend(pitch_q, gy, pitch_acc);
    e.roll = roll_q[25:0];
    e.pitch = pitch_q[25:0];
    tilt_queue.push_back(e);
  endtask

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 34);
  endfunction

  task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy);
    while (idle_now()) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.accel_x <= ax;
    samples.accel_y <= ay;
    samples.accel_z <= az;
    samples.gyro_x <= gx;
    samples.gyro_y <= gy;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    predict_tilt(ax, ay, az, gx, gy);
  endtask

  task automatic drain();
    samples.valid <= 1'b0;
    while (tilt_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == ict_pkg::CFG_FILTER_WEIGHT) weight_q = val[15:0];
    else if (idx == ict_pkg::CFG_GYRO_STEP) step_q = val;
    @(posedge clk);
  endtask

  task automatic test_directed();
    logic signed [15:0] ext [4] = '{16'sh7fff, 16'sh8000, 16'sd0, -16'sd1};
    send_sample(0, 0, 0, 0, 0);
    foreach (ext[i]) send_sample(ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[i], ext[(i+3)%4]);
    send_sample(0, 0, -16'sd100, 16'sh7fff, 16'sh7fff);
    send_sample(0, -16'sd50, -16'sd100, 16'sh8000, 16'sh8000);
    send_sample(16'sd16384, 0, 0, 0, 0);
    send_sample(-16'sd16384, 0, 0, 0, 0);
    send_sample(0, 16'sd16384, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      calm = (n > count / 2) && (n < count / 2 + 150);
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    end
    calm = 1'b0;
    drain();
  endtask

  task automatic test_config();
    write_reg(8'd7, 24'hffffff);
    write_reg(ict_pkg::CFG_FILTER_WEIGHT, 24'hff0000);
    write_reg(ict_pkg::CFG_GYRO_STEP, 24'd0);
    test_random(150);
    write_reg(ict_pkg::CFG_FILTER_WEIGHT, 24'h00ffff);
    write_reg(ict_pkg::CFG_GYRO_STEP, 24'hffffff);
    for (int n = 0; n < 40; n++) begin
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'sh7fff, 16'sh8000);
    end
    drain();
    test_random(300);
    write_reg(ict_pkg::CFG_FILTER_WEIGHT, 24'd32768);
    write_reg(ict_pkg::CFG_GYRO_STEP, 24'd327860);
    test_random(300);
  endtask

  always @(posedge clk) begin
    if (rst) angles.ready <= 1'b0;
    else angles.ready <= !idle_now();
    if (!rst && angles.valid && angles.ready) begin
      if (tilt_queue.size() == 0) begin
        $display("%0t unexpected angles roll=%0d pitch=%0d", $time,
                 angles.roll_out, angles.pitch_out);
        errors++;
      end else begin
        if (angles.roll_out !== tilt_queue[0].roll) begin
          $display("%0t roll expected %0d actual %0d", $time, tilt_queue[0].roll,
                   angles.roll_out);
          errors++;
        end
        if (angles.pitch_out !== tilt_queue[0].pitch) begin
          $display("%0t pitch expected %0d actual %0d", $time, tilt_queue[0].pitch,
                   angles.pitch_out);
          errors++;
        end
        void'(tilt_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    fill_atan();
    weight_q = 64225;
    step_q = 327860;
    roll_q = 0;
    pitch_q = 0;
    samples.valid = 1'b0;
    samples.accel_x = '0;
    samples.accel_y = '0;
    samples.accel_z = '0;
    samples.gyro_x = '0;
    samples.gyro_y = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1200);
    test_config();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
